@@ src/pfla_pkg.sv @@
// ----------------------------------------------------------------------------
// pfla_pkg
// shared types, codes and constants of the page free list allocator
// ----------------------------------------------------------------------------
package pfla_pkg;

	localparam int unsigned AddrW         = 48;
	localparam int unsigned CurW          = AddrW + 1;  // holds the top of the space itself
	localparam int unsigned PageShift     = 12;
	localparam int unsigned StackDepthDef = 1024;
	localparam int unsigned MaxRegionsDef = 16;
	localparam int unsigned FillBatchDef  = 512;

	localparam logic [CurW-1:0] PageStep = CurW'(64'd1 << PageShift);
	localparam logic [CurW-1:0] PageLow  = CurW'((64'd1 << PageShift) - 64'd1);
	localparam logic [CurW-1:0] LowLimit = CurW'(64'h10_0000);
	localparam logic [CurW-1:0] AddrTop  = {1'b1, {AddrW{1'b0}}};

	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_ALLOC = 2'd1,
		CMD_FREE  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STS_OK       = 2'd0,
		STS_OOM      = 2'd1,
		STS_FULL     = 2'd2,
		STS_TBL_FULL = 2'd3
	} status_t;

	typedef struct packed {
		logic             usable;
		logic [AddrW-1:0] length;
		logic [AddrW-1:0] base;
	} region_t;

	// page-aligned walk window of one region, limit exclusive
	typedef struct packed {
		logic [CurW-1:0] first;
		logic [CurW-1:0] limit;
	} bounds_t;

endpackage

@@ src/pfla_ram.sv @@
// ----------------------------------------------------------------------------
// pfla_ram
// single write port, single read port memory with registered read data
// ----------------------------------------------------------------------------
module pfla_ram #(
	parameter int unsigned Width = 8,
	parameter int unsigned Depth = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr,
	input  logic [Width-1:0]                         wdata,
	input  logic                                     re,
	input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr,
	output logic [Width-1:0]                         rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ src/pfla_region_eval.sv @@
// ----------------------------------------------------------------------------
// pfla_region_eval
// page-aligned walk window of one region table entry
// ----------------------------------------------------------------------------
module pfla_region_eval (
	input  pfla_pkg::region_t region,
	output pfla_pkg::bounds_t bounds
);
	import pfla_pkg::*;

	logic [CurW-1:0] up;
	logic [CurW-1:0] sum;
	logic [CurW-1:0] top;

	always_comb begin
		// start rounded up, nothing below 1 MiB
		up  = ({1'b0, region.base} + PageLow) & ~PageLow;
		// end saturated at the top of the address space, rounded down
		sum = {1'b0, region.base} + {1'b0, region.length};
		top = (sum > AddrTop) ? AddrTop : sum;
		bounds.first = (up < LowLimit) ? LowLimit : up;
		bounds.limit = top & ~PageLow;
	end

endmodule

@@ src/page_free_list_allocator.sv @@
// ----------------------------------------------------------------------------
// page_free_list_allocator
// physical page-frame allocator with a lifo free stack and lazy refill
// ----------------------------------------------------------------------------
// Each input transaction carries one command and yields exactly one result
// transaction. A region load appends base, length and usable flag to the
// region table (status 3 when the table is full). A free pushes the given
// address onto the free stack (status 2 when the stack is full, address
// dropped). An alloc pops the top of the stack; when the stack is empty it
// first refills it by walking the usable regions in order, page by page on
// 4 KiB boundaries and never below 1 MiB, pushing ascending addresses until
// FILL_BATCH pages or a full stack, then pops the highest one. Status 1 with
// address zero means out of memory. Command 3 is a no-op with status 0.
// Load, free and no-op go straight to the response state; an alloc from a
// non-empty stack first reads the top of the stack memory. On an empty
// stack the refill inspects each region with a table read, a window
// calculation and a check, pushes the pages of a usable region one by one
// and ends each walked region with a push step that finds no more pages, then
// pops the highest page, or reports out of memory when none is found. Items are
// taken one at a time: in_stall is high from acceptance until the result has
// been placed in the output register, and that register lets the next
// transaction in while an earlier result is still stalled. Both stores power
// up undefined and are only read below their fill counts, so no clearing pass
// is needed after reset.
// ----------------------------------------------------------------------------
module page_free_list_allocator #(
	parameter int unsigned STACK_DEPTH = pfla_pkg::StackDepthDef,
	parameter int unsigned MAX_REGIONS = pfla_pkg::MaxRegionsDef,
	parameter int unsigned FILL_BATCH  = pfla_pkg::FillBatchDef
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [1:0]                 cmd,
	input  logic [pfla_pkg::AddrW-1:0] region_base,
	input  logic [pfla_pkg::AddrW-1:0] region_length,
	input  logic                       region_usable,
	input  logic [pfla_pkg::AddrW-1:0] free_address,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [pfla_pkg::AddrW-1:0] page_address,
	output logic [1:0]                 status
);
	import pfla_pkg::*;

	localparam int unsigned StkAw      = $clog2(STACK_DEPTH);
	localparam int unsigned StkCw      = $clog2(STACK_DEPTH + 1);
	localparam int unsigned RegAw      = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
	localparam int unsigned RegCw      = $clog2(MAX_REGIONS + 1);
	localparam int unsigned FillCapInt = (FILL_BATCH < STACK_DEPTH) ? FILL_BATCH : STACK_DEPTH;
	localparam int unsigned RegW       = $bits(region_t);

	// a refill always starts from an empty stack, so the fill count doubles
	// as the batch counter
	localparam logic [StkCw-1:0] FillCap   = StkCw'(FillCapInt);
	localparam logic [StkCw-1:0] StackFull = StkCw'(STACK_DEPTH);
	localparam logic [RegCw-1:0] RegFull   = RegCw'(MAX_REGIONS);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_POP   = 7'b0000010,
		S_RESP  = 7'b0000100,
		S_FREAD = 7'b0001000,
		S_FCALC = 7'b0010000,
		S_FCHK  = 7'b0100000,
		S_FPUSH = 7'b1000000
	} state_t;

	state_t           state_q;
	logic [StkCw-1:0] stack_cnt_q;
	logic [RegCw-1:0] region_cnt_q;
	logic [RegCw-1:0] fill_idx_q;
	logic [CurW-1:0]  fill_addr_q;     // next page of the current region
	logic             fill_started_q;  // fill_addr_q is live for this region
	bounds_t          bounds_q;
	logic             usable_q;
	logic [AddrW-1:0] res_addr_q;
	status_t          res_status_q;
	logic             out_valid_q;
	logic [AddrW-1:0] page_address_q;
	status_t          status_q;

	// memory ports
	logic             stk_we;
	logic [StkAw-1:0] stk_waddr;
	logic [AddrW-1:0] stk_wdata;
	logic             stk_re;
	logic [StkAw-1:0] stk_raddr;
	logic [AddrW-1:0] stk_rdata;
	logic             reg_we;
	logic [RegAw-1:0] reg_waddr;
	logic [RegW-1:0]  reg_wdata;
	logic             reg_re;
	logic [RegAw-1:0] reg_raddr;
	logic [RegW-1:0]  reg_rdata;

	region_t          load_region;
	region_t          rd_region;
	bounds_t          eval_bounds;
	logic [StkCw-1:0] stk_top;
	logic             refill_go;
	logic             page_fits;
	logic             push_ok;
	logic             out_free;
	logic             out_load;
	logic             accept;

	pfla_ram #(
		.Width (AddrW),
		.Depth (STACK_DEPTH)
	) u_stack_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.re    (stk_re),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	pfla_ram #(
		.Width (RegW),
		.Depth (MAX_REGIONS)
	) u_region_ram (
		.clk   (clk),
		.we    (reg_we),
		.waddr (reg_waddr),
		.wdata (reg_wdata),
		.re    (reg_re),
		.raddr (reg_raddr),
		.rdata (reg_rdata)
	);

	assign rd_region = region_t'(reg_rdata);

	pfla_region_eval u_region_eval (
		.region (rd_region),
		.bounds (eval_bounds)
	);

	assign accept    = in_valid && (state_q == S_IDLE);
	assign in_stall  = (state_q != S_IDLE);
	assign out_free  = !out_valid_q || !out_stall;
	// result moves into the output register this cycle
	assign out_load  = (state_q == S_RESP) && out_free;
	assign stk_top   = stack_cnt_q - StkCw'(1);
	// more regions to walk and room left in this batch
	assign refill_go = (fill_idx_q < region_cnt_q) && (stack_cnt_q < FillCap);
	assign page_fits = (fill_addr_q + PageStep) <= bounds_q.limit;
	assign push_ok   = page_fits && (stack_cnt_q < FillCap);

	always_comb begin
		load_region.usable = region_usable;
		load_region.length = region_length;
		load_region.base   = region_base;
	end

	// memory access decode
	always_comb begin
		stk_we    = 1'b0;
		stk_waddr = stack_cnt_q[StkAw-1:0];
		stk_wdata = free_address;
		stk_re    = 1'b0;
		stk_raddr = stk_top[StkAw-1:0];
		reg_we    = 1'b0;
		reg_waddr = region_cnt_q[RegAw-1:0];
		reg_wdata = load_region;
		reg_re    = 1'b0;
		reg_raddr = fill_idx_q[RegAw-1:0];
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (cmd_t'(cmd))
						CMD_LOAD:  reg_we = (region_cnt_q < RegFull);
						CMD_FREE:  stk_we = (stack_cnt_q < StackFull);
						CMD_ALLOC: stk_re = (stack_cnt_q != '0);
						default:   ;
					endcase
				end
			end
			S_FREAD: begin
				if (refill_go) begin
					reg_re = 1'b1;
				end else begin
					stk_re = (stack_cnt_q != '0);
				end
			end
			S_FPUSH: begin
				stk_we    = push_ok;
				stk_wdata = fill_addr_q[AddrW-1:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			stack_cnt_q    <= '0;
			region_cnt_q   <= '0;
			fill_idx_q     <= '0;
			fill_addr_q    <= '0;
			fill_started_q <= 1'b0;
			bounds_q       <= '0;
			usable_q       <= 1'b0;
			res_addr_q     <= '0;
			res_status_q   <= STS_OK;
			out_valid_q    <= 1'b0;
			page_address_q <= '0;
			status_q       <= STS_OK;
		end else begin
			// output register fills from the response state and drains when
			// the consumer takes the transaction
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						res_addr_q <= '0;
						case (cmd_t'(cmd))
							CMD_LOAD: begin
								state_q <= S_RESP;
								if (region_cnt_q < RegFull) begin
									region_cnt_q <= region_cnt_q + RegCw'(1);
									res_status_q <= STS_OK;
								end else begin
									res_status_q <= STS_TBL_FULL;
								end
							end
							CMD_FREE: begin
								state_q <= S_RESP;
								if (stack_cnt_q < StackFull) begin
									stack_cnt_q  <= stack_cnt_q + StkCw'(1);
									res_status_q <= STS_OK;
								end else begin
									res_status_q <= STS_FULL;
								end
							end
							CMD_ALLOC: begin
								res_status_q <= STS_OK;
								if (stack_cnt_q != '0) begin
									stack_cnt_q <= stk_top;
									state_q     <= S_POP;
								end else begin
									state_q <= S_FREAD;
								end
							end
							default: begin
								res_status_q <= STS_OK;
								state_q      <= S_RESP;
							end
						endcase
					end
				end
				S_POP: begin
					res_addr_q   <= stk_rdata;
					res_status_q <= STS_OK;
					state_q      <= S_RESP;
				end
				S_RESP: begin
					if (out_free) begin
						page_address_q <= res_addr_q;
						status_q       <= res_status_q;
						state_q        <= S_IDLE;
					end
				end
				S_FREAD: begin
					if (refill_go) begin
						state_q <= S_FCALC;
					end else if (stack_cnt_q != '0) begin
						stack_cnt_q <= stk_top;
						state_q     <= S_POP;
					end else begin
						res_addr_q   <= '0;
						res_status_q <= STS_OOM;
						state_q      <= S_RESP;
					end
				end
				S_FCALC: begin
					bounds_q <= eval_bounds;
					usable_q <= rd_region.usable;
					state_q  <= S_FCHK;
				end
				S_FCHK: begin
					if (!usable_q || (bounds_q.limit <= bounds_q.first)) begin
						// unusable or empty window: move on
						fill_idx_q     <= fill_idx_q + RegCw'(1);
						fill_started_q <= 1'b0;
						state_q        <= S_FREAD;
					end else begin
						if (!fill_started_q) begin
							fill_addr_q <= bounds_q.first;
						end
						state_q <= S_FPUSH;
					end
				end
				S_FPUSH: begin
					if (push_ok) begin
						stack_cnt_q    <= stack_cnt_q + StkCw'(1);
						fill_addr_q    <= fill_addr_q + PageStep;
						fill_started_q <= 1'b1;
					end else begin
						if (!page_fits) begin
							fill_idx_q     <= fill_idx_q + RegCw'(1);
							fill_started_q <= 1'b0;
						end
						state_q <= S_FREAD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign page_address = page_address_q;
	assign status       = status_q;

endmodule
